FILE: hdl/mtse_pkg.sv
`default_nettype none

package mtse_pkg;

  localparam int DEF_FINGER_SLOTS = 5;
  localparam int INPUT_SLOTS      = 5;
  localparam int MASK_W           = 5;
  localparam int COORD_W          = 16;
  localparam int VALUE_W          = 17;
  localparam int KIND_W           = 3;
  localparam int RPT_W            = MASK_W + 2 * COORD_W * INPUT_SLOTS;
  localparam int IN_DATA_W        = ((RPT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W       = ((VALUE_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    EV_SLOT  = 3'd0,
    EV_TRACK = 3'd1,
    EV_X     = 3'd2,
    EV_Y     = 3'd3,
    EV_SYNC  = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic        capture;
    logic        emit;
    event_kind_t kind;
    logic        slot_inc;
    logic        was_upd;
  } mtse_cmd_t;

  typedef struct packed {
    logic now;
    logic was;
    logic last_slot;
    logic out_free;
  } mtse_sts_t;

endpackage

`default_nettype wire

FILE: hdl/mtse_ctrl.sv
`default_nettype none

module mtse_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      s_tvalid,
  output logic                     s_tready,
  input  wire mtse_pkg::mtse_sts_t sts,
  output mtse_pkg::mtse_cmd_t      cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SLOT,
    TRACK,
    XPOS,
    YPOS,
    SYNC
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.emit     = 1'b0;
    cmd.kind     = mtse_pkg::EV_SLOT;
    cmd.slot_inc = 1'b0;
    cmd.was_upd  = 1'b0;
    case (state)
      IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = SLOT;
        end
      end
      SLOT: begin
        cmd.kind = mtse_pkg::EV_SLOT;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.now != sts.was) begin
            state_next = TRACK;
          end else if (sts.now) begin
            state_next = XPOS;
          end else if (sts.last_slot) begin
            state_next = SYNC;
          end else begin
            cmd.slot_inc = 1'b1;
            state_next   = SLOT;
          end
        end
      end
      TRACK: begin
        cmd.kind = mtse_pkg::EV_TRACK;
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.was_upd = 1'b1;
          if (sts.now) begin
            state_next = XPOS;
          end else if (sts.last_slot) begin
            state_next = SYNC;
          end else begin
            cmd.slot_inc = 1'b1;
            state_next   = SLOT;
          end
        end
      end
      XPOS: begin
        cmd.kind = mtse_pkg::EV_X;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = YPOS;
        end
      end
      YPOS: begin
        cmd.kind = mtse_pkg::EV_Y;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_slot) begin
            state_next = SYNC;
          end else begin
            cmd.slot_inc = 1'b1;
            state_next   = SLOT;
          end
        end
      end
      SYNC: begin
        cmd.kind = mtse_pkg::EV_SYNC;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mtse_dp.sv
`default_nettype none

module mtse_dp #(
  parameter int FINGER_SLOTS = mtse_pkg::DEF_FINGER_SLOTS
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire  [mtse_pkg::IN_DATA_W-1:0]     s_tdata,
  input  wire  mtse_pkg::mtse_cmd_t          cmd,
  output mtse_pkg::mtse_sts_t                sts,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [mtse_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [mtse_pkg::KIND_W-1:0]        m_tuser,
  output logic                               m_tlast
);

  localparam int SLOT_W     = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;
  localparam int LIVE_SLOTS = (FINGER_SLOTS < mtse_pkg::INPUT_SLOTS) ?
                              FINGER_SLOTS : mtse_pkg::INPUT_SLOTS;
  localparam int CW         = mtse_pkg::COORD_W;
  localparam int VW         = mtse_pkg::VALUE_W;

  logic [mtse_pkg::RPT_W-1:0] rpt;
  logic [SLOT_W-1:0]          slot;
  logic [FINGER_SLOTS-1:0]    was_touching;
  logic                       now;
  logic [CW-1:0]              x_sel;
  logic [CW-1:0]              y_sel;
  logic [VW-1:0]              value_next;

  // slots past the input's five never touch
  always_comb begin
    now   = 1'b0;
    x_sel = '0;
    y_sel = '0;
    for (int i = 0; i < LIVE_SLOTS; i++) begin
      if (slot == SLOT_W'(i)) begin
        now   = rpt[i];
        x_sel = rpt[mtse_pkg::MASK_W + 2 * CW * i +: CW];
        y_sel = rpt[mtse_pkg::MASK_W + 2 * CW * i + CW +: CW];
      end
    end
  end

  always_comb begin
    sts.now       = now;
    sts.was       = was_touching[slot];
    sts.last_slot = (slot == SLOT_W'(FINGER_SLOTS - 1));
    sts.out_free  = !m_tvalid || m_tready;
  end

  always_comb begin
    case (cmd.kind)
      mtse_pkg::EV_SLOT:  value_next = VW'(slot);
      mtse_pkg::EV_TRACK: value_next = now ? VW'(slot) : '1;
      mtse_pkg::EV_X:     value_next = VW'(x_sel);
      mtse_pkg::EV_Y:     value_next = VW'(y_sel);
      default:            value_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rpt <= s_tdata[mtse_pkg::RPT_W-1:0];
    end
    if (cmd.capture) begin
      slot <= '0;
    end else if (cmd.slot_inc) begin
      slot <= slot + SLOT_W'(1);
    end
    if (cmd.emit) begin
      m_tdata <= mtse_pkg::OUT_DATA_W'(value_next);
      m_tuser <= cmd.kind;
      m_tlast <= (cmd.kind == mtse_pkg::EV_SYNC);
    end
    if (rst) begin
      was_touching <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cmd.was_upd) begin
        was_touching[slot] <= now;
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/multitouch_report_to_slot_events.sv
`default_nettype none

// Turns one touch report into a run of per-slot events ended by a sync event (tlast).
// Each slot gives a slot-select, then tracking id, X, Y on touch-down, tracking id -1
// on release, or X, Y while held. A report is taken, then the controller
// puts out one event per cycle through a single output register while the sink
// takes every event; back-pressure stalls it. The next report is taken as soon as the
// sync event is in the output register.

module multitouch_report_to_slot_events #(
  parameter int FINGER_SLOTS = mtse_pkg::DEF_FINGER_SLOTS
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  // finger_mask, x_slot0, y_slot0, ... x_slot4, y_slot4
  input  wire  [mtse_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // event_value
  output logic [mtse_pkg::OUT_DATA_W-1:0] m_tdata,
  // event_kind
  output logic [mtse_pkg::KIND_W-1:0]     m_tuser,
  output logic                            m_tlast
);

  mtse_pkg::mtse_cmd_t cmd;
  mtse_pkg::mtse_sts_t sts;

  mtse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtse_dp #(
    .FINGER_SLOTS (FINGER_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

FILE: hdl/mtse_checker.sv
`default_nettype none

module mtse_checker #(
  parameter int FINGER_SLOTS = mtse_pkg::DEF_FINGER_SLOTS
) (
  input wire                             clk,
  input wire                             rst,
  input wire                             s_tvalid,
  input wire                             s_tready,
  input wire                             m_tvalid,
  input wire                             m_tready,
  input wire [mtse_pkg::OUT_DATA_W-1:0]  m_tdata,
  input wire [mtse_pkg::KIND_W-1:0]      m_tuser,
  input wire                             m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output changed while stalled");

  a_sync_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == mtse_pkg::EV_SYNC)))
    else $error("tlast does not match sync event");

  a_sync_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == '0)
    else $error("sync event carries nonzero value");

  a_one_report: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("report taken while previous one is in progress");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == mtse_pkg::EV_SLOT |->
      m_tdata < mtse_pkg::OUT_DATA_W'(FINGER_SLOTS))
    else $error("slot number out of range");

endmodule

bind multitouch_report_to_slot_events mtse_checker #(
  .FINGER_SLOTS (FINGER_SLOTS)
) u_mtse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: test/multitouch_report_to_slot_events_test.sv
`default_nettype none

module multitouch_report_to_slot_events_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mtse_pkg::*;

  localparam int SLOTS = DEF_FINGER_SLOTS;
  localparam logic [VALUE_W-1:0] TRACK_RELEASE = '1;
  localparam int RANDOM_PER_PHASE = 113;

  typedef struct packed {
    logic [MASK_W-1:0]                     mask;
    logic [INPUT_SLOTS-1:0][COORD_W-1:0]   x;
    logic [INPUT_SLOTS-1:0][COORD_W-1:0]   y;
  } touch_report_t;

  typedef struct packed {
    event_kind_t        kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } slot_event_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  wire                   s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  wire                   m_tvalid;
  logic                  m_tready = 1'b0;
  wire  [OUT_DATA_W-1:0] m_tdata;
  wire  [KIND_W-1:0]     m_tuser;
  wire                   m_tlast;

  multitouch_report_to_slot_events #(.FINGER_SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  logic [SLOTS-1:0] finger_down = '0;
  slot_event_t      pending_events[$];
  int               pending_run_len[$];
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               errors = 0;
  int               reports_sent = 0;
  int               events_seen = 0;
  int               touch_downs = 0;
  int               releases = 0;
  logic [MASK_W-1:0] prev_mask = '0;
  touch_report_t    directed_rows[$];
  int               directed_len[$];

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  function automatic void put_event(event_kind_t k, logic [VALUE_W-1:0] v, logic l);
    slot_event_t e;
    e.kind  = k;
    e.value = v;
    e.last  = l;
    pending_events.push_back(e);
  endfunction

  // Expected event run for one accepted report; updates per-slot presence.
  function automatic void predict_slot_events(touch_report_t r);
    logic               now;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    for (int i = 0; i < SLOTS; i++) begin
      now = 1'b0;
      px  = '0;
      py  = '0;
      if (i < INPUT_SLOTS) begin
        now = r.mask[i];
        px  = r.x[i];
        py  = r.y[i];
      end
      put_event(EV_SLOT, VALUE_W'(i), 1'b0);
      if (now != finger_down[i]) begin
        if (now) begin
          put_event(EV_TRACK, VALUE_W'(i), 1'b0);
          put_event(EV_X, VALUE_W'(px), 1'b0);
          put_event(EV_Y, VALUE_W'(py), 1'b0);
          touch_downs++;
        end else begin
          put_event(EV_TRACK, TRACK_RELEASE, 1'b0);
          releases++;
        end
        finger_down[i] = now;
      end else if (now) begin
        put_event(EV_X, VALUE_W'(px), 1'b0);
        put_event(EV_Y, VALUE_W'(py), 1'b0);
      end
    end
    put_event(EV_SYNC, '0, 1'b1);
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_report(touch_report_t r);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[MASK_W-1:0] = r.mask;
    for (int i = 0; i < INPUT_SLOTS; i++) begin
      d[MASK_W + 2*COORD_W*i +: COORD_W]           = r.x[i];
      d[MASK_W + 2*COORD_W*i + COORD_W +: COORD_W] = r.y[i];
    end
    return d;
  endfunction

  // run_len < 0: length not typed in, content still checked by the predictor
  task automatic add_row(logic [MASK_W-1:0] m, logic [COORD_W-1:0] xb,
                         logic [COORD_W-1:0] yb, logic [COORD_W-1:0] stp, int run_len);
    touch_report_t r;
    r.mask = m;
    for (int i = 0; i < INPUT_SLOTS; i++) begin
      r.x[i] = xb + COORD_W'(i) * stp;
      r.y[i] = yb - COORD_W'(i) * stp;
    end
    directed_rows.push_back(r);
    directed_len.push_back(run_len);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Mostly plausible finger traffic: holds, single lifts/touches, plus noise.
  function automatic touch_report_t rand_report();
    touch_report_t r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r.mask = MASK_W'($urandom);
      4, 5:       r.mask = prev_mask;
      6:          r.mask = prev_mask ^ (MASK_W'(1) << $urandom_range(0, MASK_W-1));
      7:          r.mask = '0;
      8:          r.mask = '1;
      default:    r.mask = MASK_W'(1) << $urandom_range(0, MASK_W-1);
    endcase
    for (int i = 0; i < INPUT_SLOTS; i++) begin
      r.x[i] = rand_coord();
      r.y[i] = rand_coord();
    end
    prev_mask = r.mask;
    return r;
  endfunction

  task automatic send_report(touch_report_t r, int run_len);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= pack_report(r);
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_slot_events(r);
    pending_run_len.push_back(run_len);
    reports_sent++;
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : event_monitor
    slot_event_t exp_ev;
    int          run_cnt;
    int          want_len;
    if (!rst && m_tvalid && m_tready) begin
      events_seen++;
      run_cnt++;
      if (pending_events.size() == 0) begin
        flag_error($sformatf("unexpected event kind=%0d value=%h last=%b",
                             m_tuser, m_tdata, m_tlast));
      end else begin
        exp_ev = pending_events.pop_front();
        if (m_tuser !== exp_ev.kind)
          flag_error($sformatf("event_kind: expected %0d, got %0d", exp_ev.kind, m_tuser));
        if (m_tdata !== OUT_DATA_W'(exp_ev.value))
          flag_error($sformatf("event_value (kind %0d): expected %h, got %h",
                               exp_ev.kind, exp_ev.value, m_tdata));
        if (m_tlast !== exp_ev.last)
          flag_error($sformatf("last_event (kind %0d): expected %b, got %b",
                               exp_ev.kind, exp_ev.last, m_tlast));
      end
      if (m_tlast === 1'b1) begin
        if (pending_run_len.size() != 0) begin
          want_len = pending_run_len.pop_front();
          if (want_len >= 0 && run_cnt != want_len)
            flag_error($sformatf("run length: expected %0d events, got %0d",
                                 want_len, run_cnt));
        end
        run_cnt = 0;
      end
    end
  end

  initial begin
    #1000000;
    $display("multitouch_report_to_slot_events test failed");
    $finish;
  end

  initial begin
    // lengths typed in: after reset, all down, all held, all released
    add_row(5'h00, 16'h0000, 16'h0000, 16'h0000, 6);
    add_row(5'h1f, 16'h0000, 16'h0000, 16'h0000, 21);
    add_row(5'h1f, 16'hffff, 16'hffff, 16'h0000, 16);
    add_row(5'h00, 16'hffff, 16'hffff, 16'h0000, 11);
    add_row(5'h00, 16'h1234, 16'h4321, 16'h0101, -1);
    add_row(5'h01, 16'h0001, 16'hfffe, 16'h0002, -1);
    add_row(5'h02, 16'h8000, 16'h7fff, 16'h0000, -1);
    add_row(5'h04, 16'h7fff, 16'h8000, 16'h0000, -1);
    add_row(5'h08, 16'h5555, 16'haaaa, 16'h0000, -1);
    add_row(5'h10, 16'haaaa, 16'h5555, 16'h0000, -1);
    add_row(5'h10, 16'h0100, 16'hff00, 16'h0010, -1);
    add_row(5'h15, 16'h0fff, 16'hf000, 16'h1000, -1);
    add_row(5'h0a, 16'hfff0, 16'h000f, 16'h0001, -1);
    add_row(5'h0a, 16'h0000, 16'hffff, 16'h3333, -1);
    add_row(5'h1f, 16'hffff, 16'h0000, 16'h0000, -1);
    add_row(5'h1e, 16'h0000, 16'hffff, 16'h0000, -1);
    add_row(5'h0f, 16'h4000, 16'hc000, 16'h0800, -1);
    add_row(5'h1f, 16'hc000, 16'h4000, 16'h0400, -1);
    add_row(5'h00, 16'h0000, 16'h0000, 16'h0000, -1);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < directed_rows.size(); i++)
      send_report(directed_rows[i], directed_len[i]);

    // no idling / sender idle / sink stalls / both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 84; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      repeat (RANDOM_PER_PHASE) send_report(rand_report(), -1);
    end
    s_tvalid <= 1'b0;

    while (pending_events.size() != 0 || pending_run_len.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("covered %0d reports, %0d events (%0d touch-downs, %0d releases)",
             reports_sent, events_seen, touch_downs, releases);
    $display("idle/stall phases run: none, sender, sink, both; %0d mismatches", errors);
    if (errors == 0) begin
      $display("multitouch_report_to_slot_events test passed");
    end else begin
      $display("multitouch_report_to_slot_events test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hdl/mtse_pkg.sv
hdl/mtse_ctrl.sv
hdl/mtse_dp.sv
hdl/multitouch_report_to_slot_events.sv
hdl/mtse_checker.sv
test/multitouch_report_to_slot_events_test.sv
